// ===== hw/rtl/adf_pkg.sv =====
package adf_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int CFG_WIDTH   = 16;
    localparam int CFG_INDEX_WIDTH = 1;
    localparam int DATA_IN_WIDTH  = 8;
    localparam int DATA_OUT_WIDTH = 8;

    typedef logic [COUNT_WIDTH-1:0] count_t;
    typedef logic [CFG_WIDTH-1:0]   ticks_t;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_RISE_TICKS = 1'b0,
        REG_FALL_TICKS = 1'b1
    } reg_index_t;

    typedef enum logic [1:0] {
        ST_UNKNOWN = 2'd0,
        ST_LOW     = 2'd1,
        ST_HIGH    = 2'd2
    } filter_state_t;

    typedef enum logic {
        KIND_TICK   = 1'b0,
        KIND_REPORT = 1'b1
    } item_kind_t;

    typedef struct packed {
        ticks_t rise_ticks;
        ticks_t fall_ticks;
    } cfg_t;

    typedef struct packed {
        item_kind_t kind;
        logic       raw_level;
    } item_t;

    typedef struct packed {
        logic          timer_active;
        logic          changed;
        filter_state_t filtered_level;
    } result_t;

    localparam int LOAD_WIDTH = (CFG_WIDTH > COUNT_WIDTH) ? CFG_WIDTH : COUNT_WIDTH;

    // hold time, saturated to the countdown range
    function automatic count_t load_value(input ticks_t ticks);
        logic [LOAD_WIDTH-1:0] wide_ticks;
        logic [LOAD_WIDTH-1:0] wide_max;
        begin
            wide_ticks = LOAD_WIDTH'(ticks);
            wide_max   = LOAD_WIDTH'({COUNT_WIDTH{1'b1}});
            if (wide_ticks > wide_max)
            begin
                load_value = {COUNT_WIDTH{1'b1}};
            end
            else
            begin
                load_value = wide_ticks[COUNT_WIDTH-1:0];
            end
        end
    endfunction

endpackage

// ===== hw/rtl/adf_cfg_regs.sv =====
module adf_cfg_regs (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [adf_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
    input  logic [adf_pkg::CFG_WIDTH-1:0]          cfg_wdata,
    output adf_pkg::cfg_t                          cfg
);
    import adf_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rise_ticks <= ticks_t'(50);
            cfg_reg.fall_ticks <= ticks_t'(50);
        end
        else if (cfg_we)
        begin
            case (reg_index_t'(cfg_index))
                REG_RISE_TICKS: cfg_reg.rise_ticks <= cfg_wdata;
                REG_FALL_TICKS: cfg_reg.fall_ticks <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hw/rtl/adf_in_stage.sv =====
module adf_in_stage (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  adf_pkg::item_t in_item,
    input  logic           take,
    output logic           item_valid,
    output adf_pkg::item_t item
);
    import adf_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign in_ready = !valid_reg || take;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== hw/rtl/adf_core.sv =====
module adf_core (
    input  logic             clk,
    input  logic             rst_n,
    input  adf_pkg::cfg_t    cfg,
    input  logic             item_valid,
    input  adf_pkg::item_t   item,
    output logic             take,
    output logic             out_valid,
    input  logic             out_ready,
    output adf_pkg::result_t result
);
    import adf_pkg::*;

    filter_state_t state_reg;
    filter_state_t state_next;
    count_t        countdown_reg;
    count_t        countdown_next;
    logic          counting_reg;
    logic          counting_next;
    logic          changed;
    filter_state_t seen;
    logic          out_valid_reg;
    logic          out_valid_next;
    result_t       result_reg;

    assign take = item_valid && (!out_valid_reg || out_ready);
    assign seen = item.raw_level ? ST_HIGH : ST_LOW;

    always_comb
    begin
        state_next     = state_reg;
        countdown_next = countdown_reg;
        counting_next  = counting_reg;
        changed        = 1'b0;
        case (item.kind)
            KIND_REPORT:
            begin
                if (state_reg != ST_LOW && state_reg != ST_HIGH)
                begin
                    // first report is adopted directly
                    state_next = seen;
                    changed    = 1'b1;
                end
                else if (seen == state_reg)
                begin
                    counting_next = 1'b0;
                end
                else
                begin
                    countdown_next = load_value(seen == ST_HIGH ? cfg.rise_ticks
                                                                : cfg.fall_ticks);
                    counting_next  = 1'b1;
                end
            end
            KIND_TICK:
            begin
                if (counting_reg)
                begin
                    // expiry at one or zero
                    if (countdown_reg[COUNT_WIDTH-1:1] == '0)
                    begin
                        state_next     = (state_reg == ST_LOW) ? ST_HIGH : ST_LOW;
                        countdown_next = '0;
                        counting_next  = 1'b0;
                        changed        = 1'b1;
                    end
                    else
                    begin
                        countdown_next = countdown_reg - count_t'(1);
                    end
                end
            end
            default: ;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (take)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_UNKNOWN;
            countdown_reg <= '0;
            counting_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (take)
            begin
                state_reg     <= state_next;
                countdown_reg <= countdown_next;
                counting_reg  <= counting_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            result_reg.filtered_level <= state_next;
            result_reg.changed        <= changed;
            result_reg.timer_active   <= counting_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

endmodule

// ===== hw/rtl/asymmetric_debounce_filter.sv =====
// a request passes the input register, then the result register, before its result is valid
// throughput: one request per cycle while m_tready stays high; the state update is one compare and one decrement
// backpressure on the result side stalls the input register, which holds one request
// reset (rst_n, async, active low): filtered level unknown, countdown stopped at zero,
// rise and fall hold times 50 ticks, both stages empty
module asymmetric_debounce_filter (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        s_tvalid,
    output logic                                        s_tready,
    input  logic [adf_pkg::DATA_IN_WIDTH-1:0]           s_tdata,  // raw_level, zero pad
    input  logic                                        s_tuser,  // kind
    output logic                                        m_tvalid,
    input  logic                                        m_tready,
    // filtered_level[1:0], changed, timer_active, zero pad
    output logic [adf_pkg::DATA_OUT_WIDTH-1:0]          m_tdata,
    input  logic                                        cfg_we,
    input  logic [adf_pkg::CFG_INDEX_WIDTH-1:0]         cfg_index,
    input  logic [adf_pkg::CFG_WIDTH-1:0]               cfg_wdata
);
    import adf_pkg::*;

    cfg_t    cfg;
    item_t   in_item;
    item_t   item;
    logic    item_valid;
    logic    take;
    result_t result;

    assign in_item.kind      = item_kind_t'(s_tuser);
    assign in_item.raw_level = s_tdata[0];

    adf_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    adf_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    adf_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (item_valid),
        .item       (item),
        .take       (take),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .result     (result)
    );

    assign m_tdata = DATA_OUT_WIDTH'(result);

    // a change never leaves a countdown running
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[2]) |-> !m_tdata[3])
        else $error("change reported with countdown running");

    // a running countdown needs a known filtered level
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[3]) |-> (m_tdata[1:0] != ST_UNKNOWN))
        else $error("countdown running while level unknown");

    // with the result register empty the input side must be open
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty result register");

endmodule

// ===== bench/tb.sv =====
module tb;
    import adf_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 6;
    localparam int LONG_HOLD      = 200;

    logic                       clk;
    logic                       rst_n;
    logic                       s_tvalid;
    logic                       s_tready;
    logic [DATA_IN_WIDTH-1:0]   s_tdata;   // raw_level, zero pad
    logic                       s_tuser;   // kind
    logic                       m_tvalid;
    logic                       m_tready;
    logic [DATA_OUT_WIDTH-1:0]  m_tdata;   // filtered_level[1:0], changed, timer_active, pad
    logic                       cfg_we;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [CFG_WIDTH-1:0]       cfg_wdata;

    // shadow of the filter
    filter_state_t level_now    = ST_UNKNOWN;
    count_t        hold_left    = '0;
    logic          hold_running = 1'b0;
    ticks_t        rise_hold    = ticks_t'(50);
    ticks_t        fall_hold    = ticks_t'(50);

    result_t pending_levels[$];
    result_t level_want;
    result_t level_got;
    int      mismatch_count = 0;
    int      quiet_cycles   = 0;
    bit      src_idle_en    = 1'b1;
    bit      sink_idle_en   = 1'b1;
    int      sink_hold      = 0;
    int      sink_stall     = 0;

    asymmetric_debounce_filter i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic result_t debounce_step(input item_kind_t kind_v, input logic raw_v);
        filter_state_t seen;
        result_t       res;
        logic          flipped;
        begin
            seen    = raw_v ? ST_HIGH : ST_LOW;
            flipped = 1'b0;
            if (kind_v == KIND_REPORT)
            begin
                if (level_now != ST_LOW && level_now != ST_HIGH)
                begin
                    // first report is adopted, countdown untouched
                    level_now = seen;
                    flipped   = 1'b1;
                end
                else if (seen == level_now)
                begin
                    hold_running = 1'b0;
                end
                else
                begin
                    hold_left    = (seen == ST_HIGH) ? rise_hold : fall_hold;
                    hold_running = 1'b1;
                end
            end
            else if (hold_running)
            begin
                // a loaded zero expires like a one
                if (hold_left <= count_t'(1))
                begin
                    level_now    = (level_now == ST_LOW) ? ST_HIGH : ST_LOW;
                    hold_left    = '0;
                    hold_running = 1'b0;
                    flipped      = 1'b1;
                end
                else
                begin
                    hold_left = hold_left - count_t'(1);
                end
            end
            res.filtered_level = level_now;
            res.changed        = flipped;
            res.timer_active   = hold_running;
            return res;
        end
    endfunction

    // result sink with random stalls and an optional long hold-off
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (sink_hold > 0)
            begin
                m_tready <= 1'b0;
                sink_hold = sink_hold - 1;
            end
            else if (sink_stall > 0)
            begin
                m_tready <= 1'b0;
                sink_stall = sink_stall - 1;
            end
            else if (sink_idle_en && $urandom_range(0, 7) == 0)
            begin
                m_tready <= 1'b0;
                sink_stall = $urandom_range(1, 19) - 1;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    // everything sampled mid-cycle, so it holds at the following rising edge
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
            begin
                if (reg_index_t'(cfg_index) == REG_RISE_TICKS)
                    rise_hold = cfg_wdata;
                else
                    fall_hold = cfg_wdata;
            end
            if (m_tvalid && m_tready)
            begin
                if (pending_levels.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
                    mismatch_count++;
                end
                else
                begin
                    level_want = pending_levels.pop_front();
                    level_got  = result_t'(m_tdata[3:0]);
                    if (level_got !== level_want)
                    begin
                        $display("%0t: mismatch, expected %h, actual %h",
                                 $time, level_want, level_got);
                        mismatch_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                pending_levels.insert(pending_levels.size(),
                                      debounce_step(item_kind_t'(s_tuser), s_tdata[0]));
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    task automatic send_item(input item_kind_t kind_v, input logic raw_v);
        int gap;
        begin
            if (src_idle_en && $urandom_range(0, 4) == 0)
            begin
                gap = $urandom_range(1, 19);
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            s_tvalid <= 1'b1;
            s_tuser  <= kind_v;
            s_tdata  <= DATA_IN_WIDTH'(raw_v);
            @(negedge clk);
            while (!s_tready)
                @(negedge clk);
            @(posedge clk);
        end
    endtask

    // stop offering and wait for every request to come back out
    task automatic settle();
        begin
            s_tvalid <= 1'b0;
            while (pending_levels.size() != 0)
                @(posedge clk);
            repeat (SETTLE_CYCLES) @(posedge clk);
        end
    endtask

    task automatic write_hold(input reg_index_t idx, input ticks_t value);
        begin
            cfg_we    <= 1'b1;
            cfg_index <= idx;
            cfg_wdata <= value;
            @(posedge clk);
            cfg_we <= 1'b0;
            @(posedge clk);
        end
    endtask

    function automatic ticks_t pick_hold();
        begin
            case ($urandom_range(0, 9))
                0: pick_hold = '0;
                1: pick_hold = ticks_t'(1);
                9: pick_hold = ticks_t'($urandom_range(7, 40));
                default: pick_hold = ticks_t'($urandom_range(1, 6));
            endcase
        end
    endfunction

    // a bouncing pin: mostly ticks, reports follow the pin with short glitches
    task automatic send_bouncing(input int count);
        logic pin;
        int   roll;
        begin
            pin = 1'($urandom_range(0, 1));
            repeat (count)
            begin
                roll = $urandom_range(0, 11);
                if (roll == 0)
                    pin = ~pin;
                if (roll < 3)
                    send_item(KIND_REPORT, pin);
                else if (roll == 3)
                    send_item(KIND_REPORT, ~pin);
                else
                    send_item(KIND_TICK, 1'($urandom_range(0, 1)));
            end
        end
    endtask

    task automatic test_directed();
        begin
            // reset hold times of 50, level unknown
            send_item(KIND_TICK, 1'b0);
            send_item(KIND_REPORT, 1'b1);
            send_item(KIND_REPORT, 1'b0);
            repeat (3) send_item(KIND_TICK, 1'b1);
            send_item(KIND_REPORT, 1'b1);
            send_item(KIND_TICK, 1'b0);
            settle();
            // zero hold acts like one
            write_hold(REG_RISE_TICKS, ticks_t'(1));
            write_hold(REG_FALL_TICKS, '0);
            send_item(KIND_REPORT, 1'b0);
            send_item(KIND_TICK, 1'b1);
            send_item(KIND_REPORT, 1'b1);
            send_item(KIND_TICK, 1'b0);
            settle();
            write_hold(REG_RISE_TICKS, '1);
            write_hold(REG_FALL_TICKS, '1);
            send_item(KIND_REPORT, 1'b0);
            repeat (2) send_item(KIND_TICK, 1'b0);
            send_item(KIND_REPORT, 1'b0);
            send_item(KIND_REPORT, 1'b1);
            settle();
            // restart reloads the full hold time
            write_hold(REG_RISE_TICKS, ticks_t'(2));
            write_hold(REG_FALL_TICKS, ticks_t'(3));
            send_item(KIND_REPORT, 1'b0);
            send_item(KIND_TICK, 1'b0);
            send_item(KIND_REPORT, 1'b0);
            repeat (3) send_item(KIND_TICK, 1'b1);
            send_item(KIND_REPORT, 1'b1);
            repeat (2) send_item(KIND_TICK, 1'b0);
            settle();
        end
    endtask

    task automatic test_random_phases();
        begin
            repeat (5)
            begin
                write_hold(REG_RISE_TICKS, pick_hold());
                write_hold(REG_FALL_TICKS, pick_hold());
                send_bouncing(80);
                settle();
            end
        end
    endtask

    task automatic test_input_stall();
        begin
            src_idle_en  = 1'b0;
            sink_idle_en = 1'b0;
            write_hold(REG_RISE_TICKS, ticks_t'(2));
            write_hold(REG_FALL_TICKS, ticks_t'(1));
            sink_hold = LONG_HOLD;
            send_bouncing(30);
            // pause until the backlog is gone
            settle();
        end
    endtask

    task automatic test_full_rate();
        begin
            write_hold(REG_RISE_TICKS, '1);
            write_hold(REG_FALL_TICKS, ticks_t'(1));
            send_bouncing(20);
            settle();
            write_hold(REG_RISE_TICKS, ticks_t'(4));
            write_hold(REG_FALL_TICKS, ticks_t'(2));
            send_bouncing(80);
            settle();
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_phases();
        test_input_stall();
        test_full_rate();
        if (mismatch_count == 0 && pending_levels.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
